### rtl/c3f_pkg.sv
// shared constants, kernel codes and the per-channel filter function
package c3f_pkg;

    localparam int MAX_WIDTH    = 4096;
    localparam int MAX_CHANNELS = 4;

    // register indexes on the configuration port
    localparam logic [1:0] REG_IMAGE_WIDTH   = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT  = 2'd1;
    localparam logic [1:0] REG_CHANNEL_COUNT = 2'd2;
    localparam logic [1:0] REG_KERNEL_SELECT = 2'd3;

    // reset values of the width, height and channel count registers
    localparam logic [12:0] RST_IMAGE_WIDTH   = 13'd640;
    localparam logic [15:0] RST_IMAGE_HEIGHT  = 16'd480;
    localparam logic [2:0]  RST_CHANNEL_COUNT = 3'd3;

    typedef enum logic [2:0] {
        KERN_EDGE     = 3'd0,
        KERN_SHARPEN  = 3'd1,
        KERN_BOX      = 3'd2,
        KERN_GAUSS    = 3'd3,
        KERN_EMBOSS   = 3'd4,
        KERN_IDENTITY = 3'd5
    } kern_t;

    // reciprocal of 18 in 16 fractional bits, exact for sums up to 4599
    localparam logic [11:0] RECIP_18 = 12'd3641;

    // 3x3 window of one channel, p[row*3+col]; returns rounded, clamped result
    function automatic logic [7:0] c3f_filter(input logic [8:0][7:0] p, input kern_t k);
        logic signed [13:0] v [9];
        logic signed [13:0] s;
        logic [12:0] x9;
        logic [24:0] prod;
        logic [7:0]  res;
        for (int i = 0; i < 9; i++)
        begin
            v[i] = $signed({6'd0, p[i]});
        end
        s    = '0;
        x9   = '0;
        prod = '0;
        res  = '0;
        case (k)
            KERN_EDGE:
            begin
                s = (v[4] <<< 2) - v[1] - v[3] - v[5] - v[7];
            end
            KERN_SHARPEN:
            begin
                s = (v[4] <<< 2) + v[4] - v[1] - v[3] - v[5] - v[7];
            end
            KERN_BOX:
            begin
                s = v[0] + v[1] + v[2] + v[3] + v[4] + v[5] + v[6] + v[7] + v[8];
            end
            KERN_GAUSS:
            begin
                s = v[0] + v[2] + v[6] + v[8] + ((v[1] + v[3] + v[5] + v[7]) <<< 1)
                    + (v[4] <<< 2);
            end
            KERN_EMBOSS:
            begin
                s = v[4] + v[5] + v[7] + (v[8] <<< 1) - (v[0] <<< 1) - v[1] - v[3];
            end
            default:
            begin
                s = v[4];
            end
        endcase
        case (k)
            KERN_BOX:
            begin
                // sum is 0..2295: (2s+9)/18 via reciprocal multiply
                x9   = 13'({s[11:0], 1'b0}) + 13'd9;
                prod = 25'(x9) * 25'(RECIP_18);
                res  = prod[23:16];
            end
            KERN_GAUSS:
            begin
                // sum is 0..4080: (s+8)/16
                res = 8'((s + 14'sd8) >>> 4);
            end
            default:
            begin
                if (s < 0)
                begin
                    res = 8'd0;
                end
                else if (s > 14'sd255)
                begin
                    res = 8'd255;
                end
                else
                begin
                    res = s[7:0];
                end
            end
        endcase
        return res;
    endfunction

endpackage

### rtl/conv3x3_image_filter_unit.sv
// top level of the streaming 3x3 image filter with line buffers and result sequencer
//
// Pixels enter in raster order on the s_ stream, one request per pixel with up
// to four 8-bit channels in s_tdata. Filtered pixels leave on the m_ stream with
// their column and row; tlast marks the last result caused by one input pixel
// and tuser marks the final pixel of the frame. Edges are replicated.
// An input pixel produces zero to four results: none on the first row unless it
// is also the last, one per pixel but the first on later rows, one more at the
// end of each row, and on the last row both the row above and the row itself.
// Pipeline: input register with ram read, window and sequencer register, then
// the filter into the output register.
// Throughput is one pixel per clock when the receiver is ready; the sequencer
// sends one result per clock and holds the input until a pixel's results are sent.
// The receiver may stall at any time; the output register holds its request
// and back pressure reaches s_tready the same cycle.
// Reset clears counters, window and registers (640x480, 3 channels,
// identity); the line buffers need no clearing. The user writes configuration
// through the APB port only while the stream is idle; the block does not enforce it.
module conv3x3_image_filter_unit #(
    parameter int MAX_WIDTH    = c3f_pkg::MAX_WIDTH,
    parameter int MAX_CHANNELS = c3f_pkg::MAX_CHANNELS
) (
    input  logic        clk,
    input  logic        rst_n,
    // apb configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input pixels
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // in_ch0, in_ch1, in_ch2, in_ch3
    // filtered results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // out_ch0..out_ch3, out_col, out_row, zero fill
    output logic        m_tlast,   // last_in_run
    output logic        m_tuser    // frame_done
);

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int PW = 8 * MAX_CHANNELS;

    // configuration registers
    logic [12:0] width_reg;
    logic [15:0] height_reg;
    logic [2:0]  chan_reg;
    logic [2:0]  kern_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= c3f_pkg::RST_IMAGE_WIDTH;
            height_reg <= c3f_pkg::RST_IMAGE_HEIGHT;
            chan_reg   <= c3f_pkg::RST_CHANNEL_COUNT;
            kern_reg   <= 3'(c3f_pkg::KERN_IDENTITY);
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[3:2])
                c3f_pkg::REG_IMAGE_WIDTH:   width_reg  <= pwdata[12:0];
                c3f_pkg::REG_IMAGE_HEIGHT:  height_reg <= pwdata[15:0];
                c3f_pkg::REG_CHANNEL_COUNT: chan_reg   <= pwdata[2:0];
                c3f_pkg::REG_KERNEL_SELECT: kern_reg   <= pwdata[2:0];
                default:                    width_reg  <= width_reg;
            endcase
        end
    end

    assign pready = 1'b1;

    // register read back
    always_comb
    begin
        case (paddr[3:2])
            c3f_pkg::REG_IMAGE_WIDTH:   prdata = {19'd0, width_reg};
            c3f_pkg::REG_IMAGE_HEIGHT:  prdata = {16'd0, height_reg};
            c3f_pkg::REG_CHANNEL_COUNT: prdata = {29'd0, chan_reg};
            c3f_pkg::REG_KERNEL_SELECT: prdata = {29'd0, kern_reg};
            default:                    prdata = 32'd0;
        endcase
    end

    // effective geometry, channel count and kernel
    logic [14:0]        eff_w;
    logic [15:0]        eff_h;
    logic [2:0]         eff_ch;
    c3f_pkg::kern_t     eff_k;

    always_comb
    begin
        if (width_reg == 13'd0)
        begin
            eff_w = 15'd1;
        end
        else if ({2'd0, width_reg} > 15'(MAX_WIDTH))
        begin
            eff_w = 15'(MAX_WIDTH);
        end
        else
        begin
            eff_w = {2'd0, width_reg};
        end
        eff_h = (height_reg == 16'd0) ? 16'd1 : height_reg;
        if (chan_reg == 3'd0)
        begin
            eff_ch = 3'd1;
        end
        else if (chan_reg > 3'(MAX_CHANNELS))
        begin
            eff_ch = 3'(MAX_CHANNELS);
        end
        else
        begin
            eff_ch = chan_reg;
        end
        eff_k = (kern_reg > 3'(c3f_pkg::KERN_IDENTITY)) ? c3f_pkg::KERN_IDENTITY
                                                        : c3f_pkg::kern_t'(kern_reg);
    end

    // stage handshake signals
    logic in_acc;
    logic s1_adv;
    logic em_free;
    logic push;

    // position counters, advanced per accepted pixel
    logic [CW-1:0] col_reg, col_next;
    logic [15:0]   row_reg, row_next;
    logic          last_col, last_row;

    assign in_acc   = s_tvalid && s_tready;
    assign last_col = 15'(col_reg) >= (eff_w - 15'd1);
    assign last_row = row_reg >= (eff_h - 16'd1);

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (in_acc)
        begin
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? 16'd0 : row_reg + 16'd1;
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // stage 1 registers: pixel waiting for its line buffer column
    logic          s1_valid_reg;
    logic [PW-1:0] s1_pix_reg;
    logic [CW-1:0] s1_col_reg;
    logic [15:0]   s1_row_reg;
    logic          s1_lastc_reg, s1_lastr_reg;
    logic          s1_byp_reg, s1_held_reg;
    logic [PW-1:0] s1_byp_la_reg, s1_byp_lc_reg;
    logic [PW-1:0] s1_hold_la_reg, s1_hold_lc_reg;
    logic [PW-1:0] q_la, q_lc, la_eff, lc_eff;

    // line buffers: row r-2 and row r-1
    c3f_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH), .AW(CW)) u_line_above (
        .clk   (clk),
        .we    (s1_adv),
        .waddr (s1_col_reg),
        .wdata (lc_eff),
        .re    (in_acc),
        .raddr (col_reg),
        .rdata (q_la)
    );

    c3f_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH), .AW(CW)) u_line_current (
        .clk   (clk),
        .we    (s1_adv),
        .waddr (s1_col_reg),
        .wdata (s1_pix_reg),
        .re    (in_acc),
        .raddr (col_reg),
        .rdata (q_lc)
    );

    // column data seen by stage 1: held copy, forwarded write, or ram output
    always_comb
    begin
        if (s1_held_reg)
        begin
            la_eff = s1_hold_la_reg;
            lc_eff = s1_hold_lc_reg;
        end
        else if (s1_byp_reg)
        begin
            la_eff = s1_byp_la_reg;
            lc_eff = s1_byp_lc_reg;
        end
        else
        begin
            la_eff = q_la;
            lc_eff = q_lc;
        end
    end

    assign s1_adv   = s1_valid_reg && em_free;
    assign s_tready = !s1_valid_reg || s1_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_held_reg  <= 1'b0;
        end
        else
        begin
            if (in_acc)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            s1_held_reg <= s1_valid_reg && !s1_adv;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_pix_reg    <= s_tdata[PW-1:0];
            s1_col_reg    <= col_reg;
            s1_row_reg    <= row_reg;
            s1_lastc_reg  <= last_col;
            s1_lastr_reg  <= last_row;
            s1_byp_reg    <= s1_adv && (s1_col_reg == col_reg);
            s1_byp_la_reg <= lc_eff;
            s1_byp_lc_reg <= s1_pix_reg;
        end
        if (s1_valid_reg && !s1_adv)
        begin
            s1_hold_la_reg <= la_eff;
            s1_hold_lc_reg <= lc_eff;
        end
    end

    // window update: shift in the new column, replicate at the left edge
    logic [2:0][2:0][PW-1:0] win_reg, win_next;
    logic [2:0][PW-1:0]      newcol;

    always_comb
    begin
        newcol[0] = la_eff;
        newcol[1] = lc_eff;
        newcol[2] = s1_pix_reg;
        for (int i = 0; i < 3; i++)
        begin
            if (s1_col_reg == '0)
            begin
                win_next[i][0] = newcol[i];
                win_next[i][1] = newcol[i];
            end
            else
            begin
                win_next[i][0] = win_reg[i][1];
                win_next[i][1] = win_reg[i][2];
            end
            win_next[i][2] = newcol[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= '0;
        end
        else if (s1_adv)
        begin
            win_reg <= win_next;
        end
    end

    // results due for this pixel: above-left, above-right, last-left, last-right
    logic [3:0] job_mask;

    always_comb
    begin
        job_mask[0] = (s1_row_reg != 16'd0) && (s1_col_reg != '0);
        job_mask[1] = (s1_row_reg != 16'd0) && s1_lastc_reg;
        job_mask[2] = s1_lastr_reg && (s1_col_reg != '0);
        job_mask[3] = s1_lastr_reg && s1_lastc_reg;
    end

    // result sequencer registers
    logic                    em_valid_reg;
    logic [3:0]              em_pend_reg;
    logic [2:0][2:0][PW-1:0] em_win_reg;
    logic [CW-1:0]           em_col_reg;
    logic [15:0]             em_row_reg;
    logic [1:0]              em_top_n_reg, em_top_l_reg;

    logic [3:0]  pick, rest;
    logic        pick_right, pick_lastrow;

    always_comb
    begin
        pick = em_pend_reg & (~em_pend_reg + 4'd1);
        rest = em_pend_reg & ~pick;
        pick_right   = pick[1] || pick[3];
        pick_lastrow = pick[2] || pick[3];
    end

    assign push    = em_valid_reg && (!m_tvalid || m_tready);
    assign em_free = !em_valid_reg || (push && (rest == 4'd0));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            em_valid_reg <= 1'b0;
            em_pend_reg  <= '0;
        end
        else if (s1_adv)
        begin
            em_valid_reg <= |job_mask;
            em_pend_reg  <= job_mask;
        end
        else if (push)
        begin
            em_valid_reg <= |rest;
            em_pend_reg  <= rest;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            em_win_reg   <= win_next;
            em_col_reg   <= s1_col_reg;
            em_row_reg   <= s1_row_reg;
            em_top_n_reg <= (s1_row_reg >= 16'd2) ? 2'd0 : 2'd1;
            em_top_l_reg <= (s1_row_reg >= 16'd1) ? 2'd1 : 2'd2;
        end
    end

    // filter the chosen result in every active channel
    logic [2:0][1:0]  rsel, csel;
    logic [31:0]      chan_out;
    logic [CW-1:0]    res_col;
    logic [15:0]      res_row;

    always_comb
    begin
        logic [8:0][7:0] p;
        rsel[0] = pick_lastrow ? em_top_l_reg : em_top_n_reg;
        rsel[1] = pick_lastrow ? 2'd2 : 2'd1;
        rsel[2] = 2'd2;
        csel[0] = pick_right ? 2'd1 : 2'd0;
        csel[1] = pick_right ? 2'd2 : 2'd1;
        csel[2] = 2'd2;
        chan_out = '0;
        for (int ch = 0; ch < MAX_CHANNELS; ch++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    p[i*3+j] = em_win_reg[rsel[i]][csel[j]][ch*8 +: 8];
                end
            end
            if (3'(ch) < eff_ch)
            begin
                chan_out[ch*8 +: 8] = c3f_pkg::c3f_filter(p, eff_k);
            end
        end
        res_col = pick_right ? em_col_reg : em_col_reg - CW'(1);
        res_row = pick_lastrow ? em_row_reg : em_row_reg - 16'd1;
    end

    // output register
    logic        m_valid_reg;
    logic [63:0] m_data_reg;
    logic        m_last_reg, m_user_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            m_data_reg <= {4'd0, res_row, 12'(res_col), chan_out};
            m_last_reg <= (rest == 4'd0);
            m_user_reg <= pick[3];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_user_reg;

endmodule

### rtl/c3f_ram.sv
// generic single-write, single-read ram with registered read data
module c3f_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
